FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the camera pose checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under synchronous active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/cpu_pkg.sv
// ----------------------------------------------------------------------------
// cpu_pkg
// types, constants and helpers shared by the camera pose update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpu_pkg;

    // fixed-point formats
    localparam int CORDIC_STEPS  = 16;
    localparam int POS_FRAC_BITS = 16;
    localparam int DIR_FRAC_BITS = 16;
    localparam int POS_W   = 32;
    localparam int VEC_W   = DIR_FRAC_BITS + 2;
    localparam int ANG_FRAC = 30;
    localparam int DT_W    = 16;
    localparam int SPD_W   = 16;
    localparam int CX_W    = 34;
    localparam int CZ_W    = 33;
    localparam int MB_W    = (VEC_W > SPD_W + 1) ? VEC_W : SPD_W + 1;
    localparam int PROD_W  = CX_W + MB_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MOVE_SHIFT = 24 + DIR_FRAC_BITS - POS_FRAC_BITS;
    localparam int CNT_W   = (CORDIC_STEPS > 16) ? $clog2(CORDIC_STEPS) : 4;

    // constants of the pose and the rotation
    localparam logic signed [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);
    localparam logic signed [POS_W-1:0] POS_RESET_X = POS_W'(1) <<< (POS_FRAC_BITS - 1);
    localparam logic signed [POS_W-1:0] POS_RESET_Y = '0;
    localparam logic signed [POS_W-1:0] POS_RESET_Z = POS_W'(10) <<< POS_FRAC_BITS;
    localparam logic signed [VEC_W-1:0] VEC_ONE  = VEC_W'(1) <<< DIR_FRAC_BITS;
    localparam logic signed [VEC_W-1:0] VEC_MAX  = {1'b0, {(VEC_W-1){1'b1}}};
    localparam logic signed [VEC_W-1:0] VEC_MIN  = {1'b1, {(VEC_W-1){1'b0}}};
    localparam logic [SPD_W-1:0] SPEED_RESET = SPD_W'(1280);

    // sequencer counts
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] ROT_LAST    = CNT_W'(11);
    localparam logic [CNT_W-1:0] MOVE_FIRST  = CNT_W'(2);
    localparam logic [CNT_W-1:0] MOVE_LAST   = CNT_W'(4);
    localparam logic [CNT_W-1:0] SCALE_SLOT  = CNT_W'(0);

    // command codes
    localparam logic [1:0] MODE_MOVE   = 2'd0;
    localparam logic [1:0] MODE_ROTATE = 2'd1;
    localparam logic [1:0] MODE_OFFSET = 2'd2;
    localparam logic [1:0] MODE_SET    = 2'd3;
    localparam logic [1:0] AXIS_PITCH  = 2'd0;
    localparam logic [1:0] AXIS_YAW    = 2'd1;
    localparam logic [1:0] AXIS_ROLL   = 2'd2;
    localparam logic [1:0] AXIS_NONE   = 2'd3;

    // basis vector rows
    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_LOOK  = 2'd2;

    // rotation term slots within one component
    localparam logic [1:0] TERM_AX = 2'd0;
    localparam logic [1:0] TERM_BY = 2'd1;
    localparam logic [1:0] TERM_BX = 2'd2;
    localparam logic [1:0] TERM_AY = 2'd3;

    // multiplier operations, tagged through the product register
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_SCALE = 3'd1,
        OP_MOVE  = 3'd2,
        OP_AX    = 3'd3,
        OP_BY    = 3'd4,
        OP_BX    = 3'd5,
        OP_AY    = 3'd6
    } t_op;

    // controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             cordic_step;
        logic [CNT_W-1:0] step_idx;
        t_op              op;
        logic [1:0]       idx;
    } t_cmd;

    // arctangent table, Q2.30
    function automatic logic signed [CZ_W-1:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            default: v = '0;
        endcase
        return $signed({{(CZ_W-30){1'b0}}, v});
    endfunction

    // saturate a wide sum into the position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7fffffff);
        lo = -(SUM_W'(33'sh080000000));
        if (v > hi) begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end
        return v[POS_W-1:0];
    endfunction

    // saturate a wide value into the basis vector range
    function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(VEC_MAX)) begin
            return VEC_MAX;
        end else if (v < SUM_W'(VEC_MIN)) begin
            return VEC_MIN;
        end
        return v[VEC_W-1:0];
    endfunction

endpackage

FILE: src/cpu_ctrl.sv
// ----------------------------------------------------------------------------
// cpu_ctrl
// command sequencer: cordic iterations, multiplier slots and result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_mode,
    input  logic [1:0]    i_axis,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cpu_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CORDIC = 5'b00010,
        S_MAC    = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic [cpu_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_rot, n_rot;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rot   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rot   <= n_rot;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rot   = r_rot;
        o_cmd   = '{load: 1'b0, cordic_step: 1'b0, step_idx: '0,
                    op: cpu_pkg::OP_NONE, idx: 2'd0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_rot      = (i_mode == cpu_pkg::MODE_ROTATE);
                    if ((i_mode == cpu_pkg::MODE_MOVE || i_mode == cpu_pkg::MODE_ROTATE)
                        && i_axis != cpu_pkg::AXIS_NONE) begin
                        n_state = (i_mode == cpu_pkg::MODE_ROTATE) ? S_CORDIC : S_MAC;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.step_idx    = r_cnt;
                if (r_cnt == cpu_pkg::CORDIC_LAST) begin
                    n_cnt   = '0;
                    n_state = S_MAC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MAC: begin
                if (r_rot) begin
                    o_cmd.idx = r_cnt[3:2];
                    case (r_cnt[1:0])
                        cpu_pkg::TERM_AX: o_cmd.op = cpu_pkg::OP_AX;
                        cpu_pkg::TERM_BY: o_cmd.op = cpu_pkg::OP_BY;
                        cpu_pkg::TERM_BX: o_cmd.op = cpu_pkg::OP_BX;
                        default:          o_cmd.op = cpu_pkg::OP_AY;
                    endcase
                end else if (r_cnt == cpu_pkg::SCALE_SLOT) begin
                    o_cmd.op = cpu_pkg::OP_SCALE;
                end else if (r_cnt >= cpu_pkg::MOVE_FIRST) begin
                    o_cmd.op  = cpu_pkg::OP_MOVE;
                    o_cmd.idx = 2'(r_cnt - cpu_pkg::MOVE_FIRST);
                end
                if ((r_rot && r_cnt == cpu_pkg::ROT_LAST) ||
                    (!r_rot && r_cnt == cpu_pkg::MOVE_LAST)) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/cpu_dp.sv
// ----------------------------------------------------------------------------
// cpu_dp
// pose registers, cordic unit and shared multiply-accumulate path
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cpu_pkg::t_cmd                         i_cmd,
    input  logic [1:0]                            i_mode,
    input  logic [1:0]                            i_axis,
    input  logic                                  i_negate,
    input  logic [cpu_pkg::DT_W-1:0]              i_delta_time,
    input  logic signed [cpu_pkg::POS_W-1:0]      i_vec_x,
    input  logic signed [cpu_pkg::POS_W-1:0]      i_vec_y,
    input  logic signed [cpu_pkg::POS_W-1:0]      i_vec_z,
    input  logic                                  i_cfg_we,
    input  logic [cpu_pkg::SPD_W-1:0]             i_cfg_wdata,
    output logic signed [cpu_pkg::POS_W-1:0]      o_pos_x,
    output logic signed [cpu_pkg::POS_W-1:0]      o_pos_y,
    output logic signed [cpu_pkg::POS_W-1:0]      o_pos_z,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_right_x,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_right_y,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_right_z,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_up_x,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_up_y,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_up_z,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_look_x,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_look_y,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_look_z
);

    localparam int POS_W  = cpu_pkg::POS_W;
    localparam int VEC_W  = cpu_pkg::VEC_W;
    localparam int CX_W   = cpu_pkg::CX_W;
    localparam int CZ_W   = cpu_pkg::CZ_W;
    localparam int MB_W   = cpu_pkg::MB_W;
    localparam int PROD_W = cpu_pkg::PROD_W;
    localparam int SUM_W  = cpu_pkg::SUM_W;

    // registers
    logic [cpu_pkg::SPD_W-1:0]   r_speed;
    logic [1:0]                  r_axis;
    logic                        r_neg;
    logic [cpu_pkg::DT_W-1:0]    r_dt;
    logic signed [POS_W-1:0]     r_pos [3];
    logic signed [VEC_W-1:0]     r_vec [3][3];
    logic signed [CX_W-1:0]      r_cx;
    logic signed [CX_W-1:0]      r_cy;
    logic signed [CZ_W-1:0]      r_cz;
    logic [31:0]                 r_scale;
    logic signed [PROD_W-1:0]    r_prod;
    cpu_pkg::t_op                r_ptag;
    logic [1:0]                  r_pidx;
    logic signed [SUM_W-1:0]     r_acc;
    logic signed [VEC_W-1:0]     r_na;

    logic signed [POS_W-1:0]     vin [3];
    logic [1:0]                  row_a, row_b;
    logic signed [CX_W-1:0]      op_a;
    logic signed [MB_W-1:0]      op_b;
    logic signed [PROD_W-1:0]    mul;
    logic signed [SUM_W-1:0]     prod_ext;
    logic signed [SUM_W-1:0]     move_step;
    logic signed [SUM_W-1:0]     rot_sum;
    logic signed [SUM_W-1:0]     rot_rnd;
    logic signed [VEC_W-1:0]     rot_val;
    logic signed [CX_W-1:0]      c_dx, c_dy;
    logic signed [CZ_W-1:0]      c_atan;
    logic signed [CZ_W-1:0]      ang;

    assign vin[0] = i_vec_x;
    assign vin[1] = i_vec_y;
    assign vin[2] = i_vec_z;

    // rows of the rotated pair: pitch up/look, yaw right/look, roll right/up
    assign row_a = (r_axis == cpu_pkg::AXIS_PITCH) ? cpu_pkg::ROW_UP : cpu_pkg::ROW_RIGHT;
    assign row_b = (r_axis == cpu_pkg::AXIS_ROLL) ? cpu_pkg::ROW_UP : cpu_pkg::ROW_LOOK;

    // multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.op)
            cpu_pkg::OP_SCALE: begin
                op_a = CX_W'(r_dt);
                op_b = MB_W'(r_speed);
            end
            cpu_pkg::OP_MOVE: begin
                op_a = CX_W'(r_scale);
                op_b = MB_W'(r_vec[r_axis][i_cmd.idx]);
            end
            cpu_pkg::OP_AX: begin
                op_a = r_cx;
                op_b = MB_W'(r_vec[row_a][i_cmd.idx]);
            end
            cpu_pkg::OP_BY: begin
                op_a = r_cy;
                op_b = MB_W'(r_vec[row_b][i_cmd.idx]);
            end
            cpu_pkg::OP_BX: begin
                op_a = r_cx;
                op_b = MB_W'(r_vec[row_b][i_cmd.idx]);
            end
            cpu_pkg::OP_AY: begin
                op_a = r_cy;
                op_b = MB_W'(r_vec[row_a][i_cmd.idx]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul = PROD_W'(op_a) * PROD_W'(op_b);

    // product post-processing: rounded move step and rotated component
    assign prod_ext  = SUM_W'(r_prod);
    always_comb begin
        move_step = (prod_ext + (SUM_W'(1) <<< (cpu_pkg::MOVE_SHIFT - 1)))
                    >>> cpu_pkg::MOVE_SHIFT;
        if (r_neg) begin
            move_step = -move_step;
        end
        if (r_ptag == cpu_pkg::OP_BY) begin
            rot_sum = r_acc + prod_ext;
        end else begin
            rot_sum = r_acc - prod_ext;
        end
        rot_rnd = (rot_sum + (SUM_W'(1) <<< (cpu_pkg::ANG_FRAC - 1))) >>> cpu_pkg::ANG_FRAC;
        rot_val = cpu_pkg::sat_vec(rot_rnd);
    end

    // one cordic micro-rotation
    assign c_dx   = r_cy >>> i_cmd.step_idx;
    assign c_dy   = r_cx >>> i_cmd.step_idx;
    assign c_atan = cpu_pkg::atan_q30(5'(i_cmd.step_idx));
    assign ang    = CZ_W'(i_delta_time) <<< (cpu_pkg::ANG_FRAC - cpu_pkg::DT_W);

    // speed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= cpu_pkg::SPEED_RESET;
        end else if (i_cfg_we) begin
            r_speed <= i_cfg_wdata;
        end
    end

    // product tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptag <= cpu_pkg::OP_NONE;
        end else begin
            r_ptag <= i_cmd.op;
        end
    end

    // command fields, cordic and multiplier registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul;
        r_pidx <= i_cmd.idx;
        if (i_cmd.load) begin
            r_axis <= i_axis;
            r_neg  <= i_negate;
            r_dt   <= i_delta_time;
            r_cx   <= cpu_pkg::CORDIC_GAIN;
            r_cy   <= '0;
            r_cz   <= i_negate ? -ang : ang;
        end else if (i_cmd.cordic_step) begin
            if (!r_cz[CZ_W-1]) begin
                r_cx <= r_cx - c_dx;
                r_cy <= r_cy + c_dy;
                r_cz <= r_cz - c_atan;
            end else begin
                r_cx <= r_cx + c_dx;
                r_cy <= r_cy - c_dy;
                r_cz <= r_cz + c_atan;
            end
        end
        case (r_ptag)
            cpu_pkg::OP_SCALE: r_scale <= r_prod[31:0];
            cpu_pkg::OP_AX:    r_acc   <= prod_ext;
            cpu_pkg::OP_BX:    r_acc   <= prod_ext;
            cpu_pkg::OP_BY:    r_na    <= rot_val;
            default: ;
        endcase
    end

    // pose registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos[0] <= cpu_pkg::POS_RESET_X;
            r_pos[1] <= cpu_pkg::POS_RESET_Y;
            r_pos[2] <= cpu_pkg::POS_RESET_Z;
            // identity basis, with the view vector pointing down negative z
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (r != c) begin
                        r_vec[r][c] <= '0;
                    end else if (r == 2) begin
                        r_vec[r][c] <= -cpu_pkg::VEC_ONE;
                    end else begin
                        r_vec[r][c] <= cpu_pkg::VEC_ONE;
                    end
                end
            end
        end else begin
            if (i_cmd.load && i_mode == cpu_pkg::MODE_OFFSET) begin
                for (int c = 0; c < 3; c++) begin
                    r_pos[c] <= cpu_pkg::sat_pos(SUM_W'(r_pos[c]) + SUM_W'(vin[c]));
                end
            end else if (i_cmd.load && i_mode == cpu_pkg::MODE_SET) begin
                for (int c = 0; c < 3; c++) begin
                    r_pos[c] <= vin[c];
                end
            end else if (r_ptag == cpu_pkg::OP_MOVE) begin
                r_pos[r_pidx] <= cpu_pkg::sat_pos(SUM_W'(r_pos[r_pidx]) + move_step);
            end
            // both components of a pair land together, from the old values
            if (r_ptag == cpu_pkg::OP_AY) begin
                r_vec[row_a][r_pidx] <= r_na;
                r_vec[row_b][r_pidx] <= rot_val;
            end
        end
    end

    assign o_pos_x   = r_pos[0];
    assign o_pos_y   = r_pos[1];
    assign o_pos_z   = r_pos[2];
    assign o_right_x = r_vec[0][0];
    assign o_right_y = r_vec[0][1];
    assign o_right_z = r_vec[0][2];
    assign o_up_x    = r_vec[1][0];
    assign o_up_y    = r_vec[1][1];
    assign o_up_z    = r_vec[1][2];
    assign o_look_x  = r_vec[2][0];
    assign o_look_y  = r_vec[2][1];
    assign o_look_z  = r_vec[2][2];

endmodule

FILE: src/camera_pose_update.sv
// ----------------------------------------------------------------------------
// camera_pose_update
// camera position and basis keeper: move, rotate, offset and set commands
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one result beat with the whole
// pose. Offset and set produce the beat on the cycle after the command beat;
// a move runs the speed scale and then one product per component through the
// shared 34x18 multiplier; a rotation runs 16 cordic iterations followed by
// 12 products on the same multiplier. A move or rotate on axis 3 returns the
// unchanged pose on the next cycle. A new command is accepted once the result
// beat has been taken. The user must write move_speed through i_cfg_we and
// i_cfg_wdata only while no command is in flight; the block does not check it.
`timescale 1ns / 1ps

module camera_pose_update (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [cpu_pkg::SPD_W-1:0]             i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_mode,
    input  logic [1:0]                            i_axis,
    input  logic                                  i_negate,
    input  logic [cpu_pkg::DT_W-1:0]              i_delta_time,
    input  logic signed [cpu_pkg::POS_W-1:0]      i_vec_x,
    input  logic signed [cpu_pkg::POS_W-1:0]      i_vec_y,
    input  logic signed [cpu_pkg::POS_W-1:0]      i_vec_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [cpu_pkg::POS_W-1:0]      o_pos_x,
    output logic signed [cpu_pkg::POS_W-1:0]      o_pos_y,
    output logic signed [cpu_pkg::POS_W-1:0]      o_pos_z,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_right_x,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_right_y,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_right_z,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_up_x,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_up_y,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_up_z,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_look_x,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_look_y,
    output logic signed [cpu_pkg::VEC_W-1:0]      o_look_z
);

    cpu_pkg::t_cmd cmd;

    // sequencer
    cpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_axis      (i_axis),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // arithmetic and pose state
    cpu_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_mode),
        .i_axis       (i_axis),
        .i_negate     (i_negate),
        .i_delta_time (i_delta_time),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_vec_z      (i_vec_z),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_pos_z      (o_pos_z),
        .o_right_x    (o_right_x),
        .o_right_y    (o_right_y),
        .o_right_z    (o_right_z),
        .o_up_x       (o_up_x),
        .o_up_y       (o_up_y),
        .o_up_z       (o_up_z),
        .o_look_x     (o_look_x),
        .o_look_y     (o_look_y),
        .o_look_z     (o_look_z)
    );

endmodule

FILE: src/cpu_checker.sv
// ----------------------------------------------------------------------------
// cpu_checker
// port-level checks of the camera pose update block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpu_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic [1:0]                            i_mode,
    input logic [1:0]                            i_axis,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic signed [cpu_pkg::POS_W-1:0]      o_pos_x,
    input logic signed [cpu_pkg::POS_W-1:0]      o_pos_z,
    input logic signed [cpu_pkg::VEC_W-1:0]      o_right_x,
    input logic signed [cpu_pkg::VEC_W-1:0]      o_look_z
);

    // a stalled result beat stays valid and holds pos_x, pos_z, right_x and look_z
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pos_x) && $stable(o_pos_z) && $stable(o_right_x) && $stable(o_look_z))

    // one command in flight: no new command while a result waits
    `ASSERT_SAME(a_single, i_clk, i_rst_n, o_in_ready, !o_out_valid)

    // a taken result frees the input side on the next cycle
    `ASSERT_NEXT(a_release, i_clk, i_rst_n, o_out_valid && i_out_ready, o_in_ready && !o_out_valid)

    // a rotation runs through the cordic before any result
    `ASSERT_NEXT(a_rot_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_mode == cpu_pkg::MODE_ROTATE && i_axis != cpu_pkg::AXIS_NONE, !o_out_valid && !o_in_ready)

endmodule

bind camera_pose_update cpu_checker u_cpu_checker (.*);

FILE: test/pose_checker.sv
// ----------------------------------------------------------------------------
// pose_checker
// watches the command, result and speed ports of camera_pose_update, keeps
// its own copy of the pose, and compares every result beat against it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pose_checker
    import cpu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [SPD_W-1:0]         i_cfg_wdata,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [1:0]               i_mode,
    input  logic [1:0]               i_axis,
    input  logic                     i_negate,
    input  logic [DT_W-1:0]          i_delta_time,
    input  logic signed [POS_W-1:0]  i_vec_x,
    input  logic signed [POS_W-1:0]  i_vec_y,
    input  logic signed [POS_W-1:0]  i_vec_z,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic signed [VEC_W-1:0]  i_right_x,
    input  logic signed [VEC_W-1:0]  i_right_y,
    input  logic signed [VEC_W-1:0]  i_right_z,
    input  logic signed [VEC_W-1:0]  i_up_x,
    input  logic signed [VEC_W-1:0]  i_up_y,
    input  logic signed [VEC_W-1:0]  i_up_z,
    input  logic signed [VEC_W-1:0]  i_look_x,
    input  logic signed [VEC_W-1:0]  i_look_y,
    input  logic signed [VEC_W-1:0]  i_look_z,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked
);

    // one pose snapshot: 3 positions then right, up, look, vectors zero-padded
    typedef logic [11:0][31:0] pose_t;

    localparam longint VEC_HI = (64'sd1 <<< (VEC_W - 1)) - 1;
    localparam longint VEC_LO = -(64'sd1 <<< (VEC_W - 1));
    localparam longint POS_HI = 64'sh7fffffff;
    localparam longint POS_LO = -64'sh80000000;

    localparam longint ARCTAN [16] = '{
        843314857, 497837829, 263043836, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    localparam string FIELD_NAME [12] = '{
        "pos_x", "pos_y", "pos_z", "right_x", "right_y", "right_z",
        "up_x", "up_y", "up_z", "look_x", "look_y", "look_z"
    };

    longint speed;
    longint cam [3];
    longint basis [3][3];
    pose_t  pose_q [$];

    function automatic longint round_at(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // rotate rows ra and rb of the basis by ang (Q2.30), both from old values
    task automatic rotate_rows(input int ra, input int rb, input longint ang);
        longint cx;
        longint sy;
        longint z;
        longint dx;
        longint dy;
        longint na;
        longint nb;
        cx = 652032874;
        sy = 0;
        z = ang;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx -= dx; sy += dy; z -= ARCTAN[i];
            end else begin
                cx += dx; sy -= dy; z += ARCTAN[i];
            end
        end
        for (int k = 0; k < 3; k++) begin
            na = round_at(basis[ra][k] * cx + basis[rb][k] * sy, ANG_FRAC);
            nb = round_at(basis[rb][k] * cx - basis[ra][k] * sy, ANG_FRAC);
            basis[ra][k] = clip(na, VEC_LO, VEC_HI);
            basis[rb][k] = clip(nb, VEC_LO, VEC_HI);
        end
    endtask

    // apply one command to the model pose
    task automatic apply_command();
        longint scale;
        longint stride;
        longint ang;
        longint v [3];
        v[0] = i_vec_x;
        v[1] = i_vec_y;
        v[2] = i_vec_z;
        case (i_mode)
            MODE_MOVE: begin
                if (i_axis != AXIS_NONE) begin
                    scale = longint'(i_delta_time) * speed;
                    for (int k = 0; k < 3; k++) begin
                        stride = round_at(scale * basis[i_axis][k], MOVE_SHIFT);
                        if (i_negate) stride = -stride;
                        cam[k] = clip(cam[k] + stride, POS_LO, POS_HI);
                    end
                end
            end
            MODE_ROTATE: begin
                ang = longint'(i_delta_time) <<< (ANG_FRAC - 16);
                if (i_negate) ang = -ang;
                case (i_axis)
                    AXIS_PITCH: rotate_rows(ROW_UP, ROW_LOOK, ang);
                    AXIS_YAW:   rotate_rows(ROW_RIGHT, ROW_LOOK, ang);
                    AXIS_ROLL:  rotate_rows(ROW_RIGHT, ROW_UP, ang);
                    default: ;
                endcase
            end
            MODE_OFFSET: begin
                for (int k = 0; k < 3; k++) cam[k] = clip(cam[k] + v[k], POS_LO, POS_HI);
            end
            default: begin
                for (int k = 0; k < 3; k++) cam[k] = v[k];
            end
        endcase
    endtask

    function automatic pose_t model_pose();
        pose_t p;
        for (int k = 0; k < 3; k++) begin
            p[k] = cam[k][31:0];
            for (int r = 0; r < 3; r++) p[3 + 3 * r + k] = {14'b0, basis[r][k][VEC_W-1:0]};
        end
        return p;
    endfunction

    function automatic pose_t seen_pose();
        return {{14'b0, i_look_z}, {14'b0, i_look_y}, {14'b0, i_look_x},
                {14'b0, i_up_z}, {14'b0, i_up_y}, {14'b0, i_up_x},
                {14'b0, i_right_z}, {14'b0, i_right_y}, {14'b0, i_right_x},
                i_pos_z, i_pos_y, i_pos_x};
    endfunction

    // model update and result comparison
    always @(posedge i_clk) begin
        pose_t want;
        pose_t got;
        if (!i_rst_n) begin
            speed = SPEED_RESET;
            cam[0] = POS_RESET_X;
            cam[1] = POS_RESET_Y;
            cam[2] = POS_RESET_Z;
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++) basis[r][k] = 0;
            basis[ROW_RIGHT][0] = 64'sd1 <<< DIR_FRAC_BITS;
            basis[ROW_UP][1] = 64'sd1 <<< DIR_FRAC_BITS;
            basis[ROW_LOOK][2] = -(64'sd1 <<< DIR_FRAC_BITS);
            pose_q.delete();
        end else begin
            if (i_cfg_we) speed = i_cfg_wdata;
            // command beat
            if (i_in_valid && i_in_ready) begin
                apply_command();
                pose_q.push_back(model_pose());
            end
            // result beat
            if (i_out_valid && i_out_ready) begin
                got = seen_pose();
                if (pose_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("%0t: result beat with nothing expected", $realtime);
                end else begin
                    want = pose_q.pop_front();
                    o_checked++;
                    for (int f = 0; f < 12; f++) begin
                        if (want[f] !== got[f]) begin
                            o_fail_count++;
                            if (o_fail_count <= 10)
                                $display("%0t: %s expected %h got %h", $realtime,
                                         FIELD_NAME[f], want[f], got[f]);
                        end
                    end
                end
            end
        end
        o_pending = pose_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
    end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for camera_pose_update: directed corner commands, then
// random command streams under three handshake pressure profiles, with the
// speed register swept between phases; pose_checker does all the comparing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import cpu_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [SPD_W-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [1:0] i_mode = MODE_MOVE;
    logic [1:0] i_axis = AXIS_PITCH;
    logic i_negate = 1'b0;
    logic [DT_W-1:0] i_delta_time = '0;
    logic signed [POS_W-1:0] i_vec_x = '0;
    logic signed [POS_W-1:0] i_vec_y = '0;
    logic signed [POS_W-1:0] i_vec_z = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [POS_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [VEC_W-1:0] o_right_x, o_right_y, o_right_z;
    logic signed [VEC_W-1:0] o_up_x, o_up_y, o_up_z;
    logic signed [VEC_W-1:0] o_look_x, o_look_y, o_look_z;

    int fail_count;
    int pending;
    int checked;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int speed_writes = 0;
    int mode_count [4] = '{0, 0, 0, 0};

    always #6 i_clk = ~i_clk;

    camera_pose_update uut (.*);

    pose_checker u_check (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_mode, .i_axis, .i_negate, .i_delta_time, .i_vec_x, .i_vec_y, .i_vec_z,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_pos_x(o_pos_x), .i_pos_y(o_pos_y), .i_pos_z(o_pos_z),
        .i_right_x(o_right_x), .i_right_y(o_right_y), .i_right_z(o_right_z),
        .i_up_x(o_up_x), .i_up_y(o_up_y), .i_up_z(o_up_z),
        .i_look_x(o_look_x), .i_look_y(o_look_y), .i_look_z(o_look_z),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one command beat; returns on the accepting edge with valid still high
    task automatic send_cmd(input logic [1:0] mode, input logic [1:0] axis,
                            input logic neg, input logic [DT_W-1:0] dt,
                            input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] vz);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_axis <= axis;
        i_negate <= neg;
        i_delta_time <= dt;
        i_vec_x <= vx;
        i_vec_y <= vy;
        i_vec_z <= vz;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        mode_count[mode]++;
    endtask

    // stop sending and let every outstanding result drain
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || o_out_valid);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_speed(input logic [SPD_W-1:0] spd);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= spd;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        speed_writes++;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 6))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(signed'($urandom_range(0, 2097152)) - 1048576);
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return DT_W'($urandom_range(0, 2000));
            default: return DT_W'($urandom);
        endcase
    endfunction

    // weighted random command: mostly motion, some position writes
    task automatic random_cmd();
        logic [1:0] mode;
        logic [1:0] axis;
        case ($urandom_range(0, 9))
            0, 1, 2: mode = MODE_MOVE;
            3, 4, 5: mode = MODE_ROTATE;
            6, 7:    mode = MODE_OFFSET;
            default: mode = MODE_SET;
        endcase
        axis = ($urandom_range(0, 15) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
        send_cmd(mode, axis, 1'($urandom), pick_dt(), pick_coord(), pick_coord(),
                 pick_coord());
    endtask

    // random phase with a speed change every 150 commands
    task automatic random_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 149) begin
                drain();
                write_speed(SPD_W'($urandom));
            end
            random_cmd();
        end
        drain();
    endtask

    // axis codes named for moves, which share encodings with the rotate axes
    function automatic logic [1:0] AXIS_LOOK_FIX();
        return ROW_LOOK;
    endfunction

    function automatic logic [1:0] AXIS_UP_FIX();
        return ROW_UP;
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners at reset speed, sender and receiver both eager
        for (int a = 0; a < 4; a++) send_cmd(MODE_MOVE, 2'(a), a[0], '1, '0, '0, '0);
        send_cmd(MODE_MOVE, AXIS_LOOK_FIX(), 1'b1, '0, '1, '1, '1);
        for (int a = 0; a < 4; a++) send_cmd(MODE_ROTATE, 2'(a), 1'b0, '1, '0, '0, '0);
        for (int a = 0; a < 3; a++) send_cmd(MODE_ROTATE, 2'(a), 1'b1, 16'h8000, '0, '0, '0);
        send_cmd(MODE_ROTATE, AXIS_YAW, 1'b1, '0, '1, '1, '1);
        send_cmd(MODE_SET, AXIS_NONE, 1'b1, '1, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_cmd(MODE_OFFSET, AXIS_NONE, 1'b1, '1, 32'h7fffffff, 32'h80000000, 32'h00000001);
        send_cmd(MODE_OFFSET, AXIS_PITCH, 1'b0, '0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        send_cmd(MODE_SET, AXIS_PITCH, 1'b0, '0, 32'h7ffff000, 32'h80001000, '0);
        drain();

        // saturate position through moves at the speed extremes
        write_speed('1);
        send_cmd(MODE_MOVE, AXIS_PITCH, 1'b0, '1, '0, '0, '0);
        send_cmd(MODE_MOVE, AXIS_UP_FIX(), 1'b1, '1, '0, '0, '0);
        send_cmd(MODE_MOVE, AXIS_ROLL, 1'b0, '1, '0, '0, '0);
        drain();
        write_speed('0);
        send_cmd(MODE_MOVE, AXIS_PITCH, 1'b0, '1, '0, '0, '0);
        drain();

        random_phase(550, 14, 82);
        write_speed('1);
        random_phase(550, 82, 14);
        write_speed(SPD_W'(1));
        random_phase(550, 0, 0);

        repeat (40) @(posedge i_clk);
        $display("covered %0d commands: %0d move, %0d rotate, %0d offset, %0d set",
                 mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3],
                 mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
        $display("%0d poses compared over %0d speed settings", checked, speed_writes + 1);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/cpu_pkg.sv
src/cpu_ctrl.sv
src/cpu_dp.sv
src/camera_pose_update.sv
src/cpu_checker.sv
test/pose_checker.sv
test/testbench.sv
